FILE: rtl/core/rbsd_pkg.sv
// Shared types, widths and arithmetic helpers for the RGB box3 smoothing block.
// No dependencies; used by rgb_box3_smooth_distance.
package rbsd_pkg;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int DIST_W   = 9;
    localparam int MEAN_W   = 17;
    localparam int SQ_W     = 18;   // sum of three 8-bit squares
    localparam int ROOT_REM_W = 10; // root remainder stays below 2*root+1
    localparam int MAX_DIST = 441;  // floor(sqrt(3*255^2))
    localparam int Q_FRAC_W = 8;    // fraction bits of the mean

    localparam int MAX_FRAME_PIXELS_DEF = 1024;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_pixel;

    // floor(s/3) for s < 768 by reciprocal multiply: (s*683) >> 11
    function automatic logic [CHAN_W-1:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        return p[18:11];
    endfunction

    // Three-tap box average of one channel, truncated
    function automatic logic [CHAN_W-1:0] box3(input logic [CHAN_W-1:0] l,
                                               input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] r);
        logic [9:0] s;
        s = 10'(l) + 10'(c) + 10'(r);
        return div3(s);
    endfunction

    // Absolute difference of two channel values
    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/core/rgb_box3_smooth_distance.sv
// A pixel's result is registered after the request of its right neighbor, through the
// steps filter, squares, bit-serial root and output; the output step waits while the
// output register holds an unaccepted result. A new pixel is taken only in idle, once
// the result is registered. At frame end the last pixel passes the same steps, then the bit-serial mean divider runs.
// Reset (i_rst_n low, synchronous) empties the window, counters and output register.
// Depends on rbsd_pkg.
module rgb_box3_smooth_distance #(
    parameter int MAX_FRAME_PIXELS = rbsd_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rbsd_pkg::CHAN_W-1:0] i_red_in,
    input  logic [rbsd_pkg::CHAN_W-1:0] i_green_in,
    input  logic [rbsd_pkg::CHAN_W-1:0] i_blue_in,
    input  logic                       i_frame_end,
    // result request channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rbsd_pkg::CHAN_W-1:0] o_red_smooth,
    output logic [rbsd_pkg::CHAN_W-1:0] o_green_smooth,
    output logic [rbsd_pkg::CHAN_W-1:0] o_blue_smooth,
    output logic [rbsd_pkg::DIST_W-1:0] o_color_distance,
    output logic [rbsd_pkg::MEAN_W-1:0] o_mean_distance,
    output logic                       o_is_summary,
    output logic                       o_final_item
);

    localparam int CW  = $clog2(MAX_FRAME_PIXELS + 1);              // pixel count
    localparam int TW  = $clog2(rbsd_pkg::MAX_DIST * MAX_FRAME_PIXELS + 1); // total
    localparam int DW  = TW + rbsd_pkg::Q_FRAC_W;                    // dividend bits
    localparam int STW = $clog2(DW);                                 // step counter
    localparam int CH  = rbsd_pkg::CHAN_W;
    localparam int RW  = rbsd_pkg::ROOT_REM_W;
    localparam int DSW = rbsd_pkg::DIST_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FILT, S_SQ, S_ROOT, S_PUT, S_DIV, S_SUM
    } t_state;

    t_state r_state;

    // frame state
    rbsd_pkg::t_pixel r_prior, r_older, r_cur;
    logic [CW-1:0]    r_count;
    logic [TW-1:0]    r_total;
    logic             r_last;
    logic             r_second;   // current job is the frame's final pixel

    // pixel job
    rbsd_pkg::t_pixel r_left, r_ctr, r_right, r_smooth;
    logic [2:0][CH-1:0] r_diff;
    logic [STW-1:0]   r_step;
    logic [rbsd_pkg::SQ_W-1:0] r_rad;
    logic [RW-1:0]    r_sqr_rem;
    logic [DSW-1:0]   r_root;

    // divider
    logic [DW-1:0]    r_dvd;
    logic [CW-1:0]    r_dvs;
    logic [CW-1:0]    r_div_rem;
    logic [rbsd_pkg::MEAN_W-1:0] r_quo;

    // output register
    logic              r_o_valid;
    rbsd_pkg::t_pixel  r_o_smooth;
    logic [DSW-1:0]    r_o_dist;
    logic [rbsd_pkg::MEAN_W-1:0] r_o_mean;
    logic              r_o_sum;

    // Combinational helpers
    rbsd_pkg::t_pixel w_cur, w_smooth;
    logic             w_last_in, w_out_free, w_put_res;
    logic [2*CH-1:0]  w_sq;
    logic [RW+1:0]    w_rs, w_trial;
    logic             w_root_ge;
    logic [CW:0]      w_drem;
    logic             w_div_ge;

    assign w_cur      = '{r: i_red_in, g: i_green_in, b: i_blue_in};
    assign w_last_in  = i_frame_end || (r_count == CW'(MAX_FRAME_PIXELS - 1));
    assign w_out_free = !r_o_valid || i_ready;
    assign w_put_res  = ((r_state == S_PUT) || (r_state == S_SUM)) && w_out_free;

    // box filter of all three channels
    always_comb begin
        w_smooth.r = rbsd_pkg::box3(r_left.r, r_ctr.r, r_right.r);
        w_smooth.g = rbsd_pkg::box3(r_left.g, r_ctr.g, r_right.g);
        w_smooth.b = rbsd_pkg::box3(r_left.b, r_ctr.b, r_right.b);
    end

    // one square per cycle from the difference shift register
    assign w_sq = {{CH{1'b0}}, r_diff[0]} * {{CH{1'b0}}, r_diff[0]};

    // square root: two radicand bits per step
    assign w_rs      = {r_sqr_rem, r_rad[rbsd_pkg::SQ_W-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_root_ge = (w_rs >= w_trial);

    // restoring division: one dividend bit per step
    assign w_drem   = {r_div_rem, r_dvd[DW-1]};
    assign w_div_ge = (w_drem >= {1'b0, r_dvs});

    // Control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prior   <= '0;
            r_older   <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_last    <= 1'b0;
            r_second  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // output register: load a new result, else release the accepted one
            if (w_put_res) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur  <= w_cur;
                        r_last <= w_last_in;
                        if (r_count != '0) begin
                            // previous pixel now has its right neighbor
                            r_left   <= r_older;
                            r_ctr    <= r_prior;
                            r_right  <= w_cur;
                            r_second <= 1'b0;
                            r_state  <= S_FILT;
                        end else if (w_last_in) begin
                            // one-pixel frame
                            r_left   <= '0;
                            r_ctr    <= w_cur;
                            r_right  <= '0;
                            r_second <= 1'b1;
                            r_state  <= S_FILT;
                        end else begin
                            r_older <= r_prior;
                            r_prior <= w_cur;
                            r_count <= CW'(1);
                        end
                    end
                end
                S_FILT: begin
                    r_smooth  <= w_smooth;
                    r_diff[0] <= rbsd_pkg::absdiff(r_ctr.r, w_smooth.r);
                    r_diff[1] <= rbsd_pkg::absdiff(r_ctr.g, w_smooth.g);
                    r_diff[2] <= rbsd_pkg::absdiff(r_ctr.b, w_smooth.b);
                    r_rad     <= '0;
                    r_sqr_rem <= '0;
                    r_root    <= '0;
                    r_step    <= STW'(2);
                    r_state   <= S_SQ;
                end
                S_SQ: begin
                    r_rad  <= r_rad + rbsd_pkg::SQ_W'(w_sq);
                    r_diff <= {{CH{1'b0}}, r_diff[2:1]};
                    if (r_step == '0) begin
                        r_step  <= STW'(8);
                        r_state <= S_ROOT;
                    end else begin
                        r_step <= r_step - STW'(1);
                    end
                end
                S_ROOT: begin
                    r_rad     <= r_rad << 2;
                    r_sqr_rem <= RW'(w_root_ge ? (w_rs - w_trial) : w_rs);
                    r_root    <= {r_root[DSW-2:0], w_root_ge};
                    if (r_step == '0) begin
                        r_state <= S_PUT;
                    end else begin
                        r_step <= r_step - STW'(1);
                    end
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_o_smooth <= r_smooth;
                        r_o_dist   <= r_root;
                        r_o_mean   <= '0;
                        r_o_sum    <= 1'b0;
                        r_total    <= r_total + TW'(r_root);
                        if (r_second) begin
                            // frame mean: (total << 8) / count
                            r_dvd     <= {r_total + TW'(r_root),
                                          {rbsd_pkg::Q_FRAC_W{1'b0}}};
                            r_dvs     <= r_count + CW'(1);
                            r_div_rem <= '0;
                            r_quo     <= '0;
                            r_step    <= STW'(DW - 1);
                            r_state   <= S_DIV;
                        end else if (r_last) begin
                            r_left   <= r_prior;
                            r_ctr    <= r_cur;
                            r_right  <= '0;
                            r_second <= 1'b1;
                            r_state  <= S_FILT;
                        end else begin
                            r_older <= r_prior;
                            r_prior <= r_cur;
                            r_count <= r_count + CW'(1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_dvd     <= r_dvd << 1;
                    r_div_rem <= CW'(w_div_ge ? (w_drem - {1'b0, r_dvs}) : w_drem);
                    r_quo     <= {r_quo[rbsd_pkg::MEAN_W-2:0], w_div_ge};
                    if (r_step == '0) begin
                        r_state <= S_SUM;
                    end else begin
                        r_step <= r_step - STW'(1);
                    end
                end
                S_SUM: begin
                    if (w_out_free) begin
                        r_o_smooth <= '0;
                        r_o_dist   <= '0;
                        r_o_mean   <= r_quo;
                        r_o_sum    <= 1'b1;
                        // new frame
                        r_prior  <= '0;
                        r_older  <= '0;
                        r_count  <= '0;
                        r_total  <= '0;
                        r_second <= 1'b0;
                        r_last   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_red_smooth     = r_o_smooth.r;
    assign o_green_smooth   = r_o_smooth.g;
    assign o_blue_smooth    = r_o_smooth.b;
    assign o_color_distance = r_o_dist;
    assign o_mean_distance  = r_o_mean;
    assign o_is_summary     = r_o_sum;
    assign o_final_item     = r_o_sum;

    // Checks

    // root remainder never exceeds twice the root once the root is done
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> ({1'b0, r_sqr_rem} <= {1'b0, r_root, 1'b0}))
        else $error("square root remainder out of range");

    // a pixel distance stays within the largest possible color error
    a_dist_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_sum) |-> (r_o_dist <= DSW'(rbsd_pkg::MAX_DIST)))
        else $error("pixel distance too large");

    // the frame mean cannot exceed the largest distance in Q.8
    a_mean_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_sum) |->
        (r_o_mean <= rbsd_pkg::MEAN_W'(rbsd_pkg::MAX_DIST * 256)))
        else $error("frame mean too large");

    // the pixel count stays below the frame bound
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= CW'(MAX_FRAME_PIXELS - 1)))
        else $error("pixel count beyond frame bound");

    // a summary ends the frame: window and totals are empty afterwards
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && w_out_free) |=>
        (r_count == '0 && r_total == '0 && r_state == S_IDLE))
        else $error("frame state not cleared after summary");

endmodule
